>>> hw/rtl/sbl_pkg.sv
package sbl_pkg;

  localparam int KEY_W            = 8;
  localparam int COUNT_OUT_W      = 5;
  localparam int STATUS_W         = 2;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic             en;
    logic             op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  // Per-cell compare results.
  typedef struct packed {
    logic gt;     // slot is empty or greater than the key
    logic match;  // slot holds an entry equal to the key
  } flag_t;

endpackage

>>> hw/rtl/sbl_cell.sv
module sbl_cell (
  input  logic                       clk,
  input  sbl_pkg::cmd_t              cmd,
  input  logic                       valid,
  input  logic [sbl_pkg::KEY_W-1:0]  left_value,
  input  logic                       left_gt,
  input  logic [sbl_pkg::KEY_W-1:0]  right_value,
  output logic [sbl_pkg::KEY_W-1:0]  value,
  output sbl_pkg::flag_t             flags
);

  logic [sbl_pkg::KEY_W-1:0] value_r;
  logic [sbl_pkg::KEY_W-1:0] value_nxt;
  logic                      gt;
  logic                      ge;

  assign gt          = !valid || (value_r > cmd.key);
  assign ge          = !valid || (value_r >= cmd.key);
  assign flags.gt    = gt;
  assign flags.match = valid && (value_r == cmd.key);
  assign value       = value_r;

  // Insert shifts every entry from the insert point one place right; remove
  // pulls every entry from the matching slot one place left.
  always_comb begin
    value_nxt = value_r;
    if (cmd.en) begin
      if (cmd.op == sbl_pkg::OP_INSERT) begin
        if (left_gt) begin
          value_nxt = left_value;
        end else if (gt) begin
          value_nxt = cmd.key;
        end
      end else if (ge) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

>>> hw/rtl/sorted_byte_list_insert_remove.sv
// Channel   Direction  Handshake            Payload
// request   in         start / busy         in_operation, in_key
// result    out        out_strobe (1 cycle) out_status, out_entry_count,
//                                           out_is_empty, out_smallest
//
// Each request is captured at the accept edge, and the next cycle runs the
// compare-and-shift across the whole row of cells. The result strobes in the
// cycle after that, and the next request is accepted at the edge that ends
// that strobe cycle, so a new request is only taken once the last has updated the row.
// Reset is synchronous and active low and empties the list with no clearing
// pass, since cells are only read below the count; the receiver cannot stall.
module sorted_byte_list_insert_remove #(
  parameter int CAPACITY = sbl_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [sbl_pkg::KEY_W-1:0]        in_key,
  output logic                             out_strobe,
  output logic [sbl_pkg::STATUS_W-1:0]     out_status,
  output logic [sbl_pkg::COUNT_OUT_W-1:0]  out_entry_count,
  output logic                             out_is_empty,
  output logic [sbl_pkg::KEY_W-1:0]        out_smallest
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Request capture and control.
  logic                          busy_r;
  logic                          strobe_r;
  logic                          op_r;
  logic [sbl_pkg::KEY_W-1:0]     key_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [CNT_W-1:0]              cnt_nxt;
  logic [sbl_pkg::STATUS_W-1:0]  status_r;
  logic [sbl_pkg::STATUS_W-1:0]  status_nxt;
  logic                          accept;
  logic                          full;
  logic                          found;
  sbl_pkg::cmd_t                 cmd;

  // Row of cells and the wires between neighbors.
  logic [sbl_pkg::KEY_W-1:0]     cell_value [CAPACITY];
  sbl_pkg::flag_t                cell_flags [CAPACITY];
  logic [CAPACITY-1:0]           match_vec;
  logic [31:0]                   cnt_ext;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign found  = |match_vec;

  // The row only changes in the update cycle, and only when the request can
  // take effect: an insert needs a free slot, a remove needs a match.
  assign cmd.op  = op_r;
  assign cmd.key = key_r;
  assign cmd.en  = busy_r && ((op_r == sbl_pkg::OP_INSERT) ? !full : found);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic [sbl_pkg::KEY_W-1:0] left_value;
    logic                      left_gt;
    logic [sbl_pkg::KEY_W-1:0] right_value;

    // The first cell never receives from the left; the last cell keeps its
    // own value on a remove because that slot drops out of the count.
    if (i == 0) begin : g_first
      assign left_value = key_r;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_flags[i-1].gt;
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_next
      assign right_value = cell_value[i+1];
    end

    sbl_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .valid       (IDX < cnt_r),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .flags       (cell_flags[i])
    );

    assign match_vec[i] = cell_flags[i].match;
  end

  // Status and count for the request in its update cycle.
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = sbl_pkg::STATUS_DONE;
    if (op_r == sbl_pkg::OP_INSERT) begin
      if (full) begin
        status_nxt = sbl_pkg::STATUS_FULL;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else begin
      if (found) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end else begin
        status_nxt = sbl_pkg::STATUS_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      strobe_r <= busy_r;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
    if (busy_r) begin
      status_r <= status_nxt;
    end
  end

  // Results come straight from registers, which hold through the strobe
  // cycle because a request accepted then only updates them at the end of its update cycle.
  assign cnt_ext         = 32'(cnt_r);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_count = cnt_ext[sbl_pkg::COUNT_OUT_W-1:0];
  assign out_is_empty    = (cnt_r == '0);
  assign out_smallest    = (cnt_r == '0) ? '0 : cell_value[0];

  // Every update cycle is followed by exactly one result strobe.
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> out_strobe)
    else $error("result strobe missing after update cycle");

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A full status is only reported while every cell is occupied.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == sbl_pkg::STATUS_FULL)) |-> full)
    else $error("full status reported with free cells");

  // The two front entries stay in ascending order.
  if (CAPACITY > 1) begin : g_order_check
    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r >= CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
      else $error("front entries out of order");
  end

endmodule

>>> tb/sorted_byte_list_checker.sv
`timescale 1ns / 1ps

module sorted_byte_list_checker #(
  parameter int CAPACITY = sbl_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             in_operation,
  input  logic [sbl_pkg::KEY_W-1:0]        in_key,
  input  logic                             out_strobe,
  input  logic [sbl_pkg::STATUS_W-1:0]     out_status,
  input  logic [sbl_pkg::COUNT_OUT_W-1:0]  out_entry_count,
  input  logic                             out_is_empty,
  input  logic [sbl_pkg::KEY_W-1:0]        out_smallest,
  output int                               mismatch_count,
  output int                               pending_count
);

  import sbl_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
    logic [KEY_W-1:0]       smallest;
  } list_result_t;

  // Shadow of the sorted store, kept in ascending order.
  logic [KEY_W-1:0] held_keys [CAPACITY];
  int               held_count;
  list_result_t     expected_results [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    held_count     = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic list_result_t apply_request(logic op, logic [KEY_W-1:0] key);
    list_result_t r;
    int pos;
    pos = 0;
    if (op == OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        while (pos < held_count && held_keys[pos] <= key) pos++;
        for (int j = held_count; j > pos; j--) held_keys[j] = held_keys[j-1];
        held_keys[pos] = key;
        held_count++;
        r.status = STATUS_DONE;
      end
    end else begin
      while (pos < held_count && held_keys[pos] < key) pos++;
      if (pos >= held_count || held_keys[pos] != key) begin
        r.status = STATUS_NOT_FOUND;
      end else begin
        for (int j = pos; j + 1 < held_count; j++) held_keys[j] = held_keys[j+1];
        held_count--;
        r.status = STATUS_DONE;
      end
    end
    r.entry_count = held_count[COUNT_OUT_W-1:0];
    r.is_empty    = (held_count == 0);
    r.smallest    = (held_count > 0) ? held_keys[0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", int'(out_status), int'(want.status));
          if (out_entry_count !== want.entry_count)
            report_mismatch("entry_count", int'(out_entry_count),
                            int'(want.entry_count));
          if (out_is_empty !== want.is_empty)
            report_mismatch("is_empty", int'(out_is_empty), int'(want.is_empty));
          if (out_smallest !== want.smallest)
            report_mismatch("smallest", int'(out_smallest), int'(want.smallest));
        end
      end
      if (start && !busy) expected_results.push_back(apply_request(in_operation, in_key));
    end
    pending_count = expected_results.size();
  end

endmodule

>>> tb/sorted_byte_list_insert_remove_test.sv
`timescale 1ns / 1ps

module sorted_byte_list_insert_remove_test;

  import sbl_pkg::*;

  localparam int CAPACITY      = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS  = 1430;
  // Even with the longest gap after every request the run stays far below
  // this limit, so the limit only trips on a hang.
  localparam int CYCLE_LIMIT   = 200000;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_operation;
  logic [KEY_W-1:0]       in_key;
  logic                   out_strobe;
  logic [STATUS_W-1:0]    out_status;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic                   out_is_empty;
  logic [KEY_W-1:0]       out_smallest;
  int                     mismatch_count;
  int                     pending_count;
  int                     cycle_count;

  sorted_byte_list_insert_remove #(.CAPACITY(CAPACITY)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_smallest    (out_smallest)
  );

  // The checker watches both channels, keeps its own copy of the sorted
  // store, and compares every result against the oldest pending prediction.
  sorted_byte_list_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_smallest    (out_smallest),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hang anywhere in the run ends it here with a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Presents one request at the falling edge and holds it until a rising
  // edge sees busy low. Start stays high on return, so a request that
  // follows at once replaces the payload at the falling edge with no dip
  // in start.
  task automatic send_request(logic op, logic [KEY_W-1:0] key);
    @(negedge clk);
    start        = 1'b1;
    in_operation = op;
    in_key       = key;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // Drops start for a number of cycles so that gaps land on every phase of
  // the accept and update sequence.
  task automatic idle_cycles(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Keys are drawn from a few narrow clusters most of the time, so that
  // removes find their key and duplicates pile up; the rest span the
  // whole byte range so every key bit toggles.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] cluster;
    if ($urandom_range(0, 99) < 60) begin
      case ($urandom_range(0, 2))
        0:       cluster = 8'h00;
        1:       cluster = 8'h7E;
        default: cluster = 8'hFC;
      endcase
      return cluster + KEY_W'($urandom_range(0, 3));
    end
    return KEY_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int sent;
    int burst_left;
    int insert_pct;
    logic op;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_INSERT;
    in_key       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: remove from an empty store, the key extremes, a
    // duplicate key, a miss, then a fill to capacity with an insert into
    // the full store and a miss while full.
    send_request(OP_REMOVE, 8'h00);
    send_request(OP_INSERT, 8'hFF);
    send_request(OP_INSERT, 8'h00);
    send_request(OP_INSERT, 8'h00);
    idle_cycles(1);
    send_request(OP_INSERT, 8'h80);
    send_request(OP_REMOVE, 8'h05);
    send_request(OP_REMOVE, 8'h00);
    for (int i = 0; i < CAPACITY - 3; i++) send_request(OP_INSERT, KEY_W'(i * 19 + 3));
    send_request(OP_INSERT, 8'h55);
    send_request(OP_REMOVE, 8'h01);
    send_request(OP_REMOVE, 8'hFF);
    send_request(OP_REMOVE, 8'h00);

    // Random part: the insert share swings between phases so that the
    // store repeatedly fills up and drains, and the sender works in bursts.
    sent       = 0;
    burst_left = 0;
    insert_pct = 50;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      if (burst_left == 0) begin
        // About one burst in four follows on without any gap.
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      send_request(op, pick_key());
      burst_left--;
      sent++;
    end

    // Drain: wait for every predicted result, then a few cycles more to
    // catch any stray strobe.
    @(negedge clk);
    start = 1'b0;
    wait (pending_count == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sbl_pkg.sv
hw/rtl/sbl_cell.sv
hw/rtl/sorted_byte_list_insert_remove.sv
tb/sorted_byte_list_checker.sv
tb/sorted_byte_list_insert_remove_test.sv
